// ----- rtl/ptst_pkg.sv -----
// Shared types and constants for the periodic timer slot table.
`default_nettype none
package ptst_pkg;
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W = 4;

  localparam logic [1:0] CMD_REG   = 2'd0;
  localparam logic [1:0] CMD_UNREG = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_UNREG = 2'd1;
  localparam logic [1:0] KIND_FIRE  = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TAG  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic        zero;
  } mod_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/ptst_mod_unit.sv -----
// Restoring bit-serial 32-by-16 remainder unit; reports whether remainder is zero.
`default_nettype none
module ptst_mod_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ptst_pkg::mod_req_t req,
  output ptst_pkg::mod_rsp_t     rsp
);
  import ptst_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (trial >= {1'b0, div_r}) rem_nxt = trial - {1'b0, div_r};
      else rem_nxt = trial;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == 17'd0);
endmodule
`default_nettype wire

// ----- rtl/periodic_timer_slot_table.sv -----
// Top level: slot table, free-slot FIFO and command sequencer.
`default_nettype none
// Register and unregister each give one word. A tick scans the 16
// slots in order; each live slot with a nonzero interval also runs the
// shared bit-serial remainder unit, and each firing slot gives one fire
// word, which waits on out_stall. Up to 16 fire words then one tick-done
// word (last set) come out per tick. The block takes no word while a
// command is in progress.
module periodic_timer_slot_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_handler_tag,
  input  wire logic [15:0] in_interval,
  input  wire logic signed [15:0] in_repeat_count,
  input  wire logic [7:0]  in_slot_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_status,
  output logic [5:0]       out_result_slot,
  output logic [7:0]       out_fired_handler,
  output logic [31:0]      out_tick_count,
  output logic             out_last
);
  import ptst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_FIRE, S_OUT} state_t;

  state_t state_r;
  logic [7:0]  hnd_r [SLOT_COUNT];
  logic [15:0] per_r [SLOT_COUNT];
  logic signed [15:0] rep_r [SLOT_COUNT];
  logic [5:0]  fifo_r [SLOT_COUNT];
  logic [SLOT_W-1:0] head_r, tail_r, idx_r;
  logic [SLOT_W:0]   fill_r;
  logic [31:0] ticks_r;
  logic        scan_end_r;
  mod_req_t    req;
  mod_rsp_t    rsp;

  ptst_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_stall = (state_r != S_IDLE);
  assign req.start = (state_r == S_SCAN) && !scan_end_r &&
                     hnd_r[idx_r] != 8'd0 && per_r[idx_r] != 16'd0;
  assign req.dividend = ticks_r;
  assign req.divisor = per_r[idx_r];

  logic signed [15:0] rep_dec;
  assign rep_dec = (rep_r[idx_r] > 16'sd0) ? rep_r[idx_r] - 16'sd1 : rep_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= (SLOT_W+1)'(SLOT_COUNT);
      ticks_r <= '0;
      idx_r <= '0;
      scan_end_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        hnd_r[i] <= '0;
        per_r[i] <= '0;
        rep_r[i] <= '0;
        fifo_r[i] <= 6'(i);
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          out_status <= ST_OK;
          out_result_slot <= '0;
          out_fired_handler <= '0;
          out_tick_count <= '0;
          out_last <= 1'b1;
          priority if (in_command == CMD_REG) begin
            out_kind <= KIND_REG;
            out_valid <= 1'b1;
            state_r <= S_OUT;
            if (in_handler_tag == 8'd0) out_status <= ST_NO_TAG;
            else if (fill_r == '0) out_status <= ST_FULL;
            else begin
              hnd_r[fifo_r[head_r][SLOT_W-1:0]] <= in_handler_tag;
              per_r[fifo_r[head_r][SLOT_W-1:0]] <= in_interval;
              rep_r[fifo_r[head_r][SLOT_W-1:0]] <= in_repeat_count;
              out_result_slot <= {2'b0, fifo_r[head_r][SLOT_W-1:0]};
              head_r <= head_r + 1'b1;
              fill_r <= fill_r - 1'b1;
            end
          end else if (in_command == CMD_UNREG) begin
            out_kind <= KIND_UNREG;
            out_valid <= 1'b1;
            state_r <= S_OUT;
            if (in_slot_number >= 8'(SLOT_COUNT) ||
                hnd_r[in_slot_number[SLOT_W-1:0]] == 8'd0) out_status <= ST_BAD;
            else begin
              hnd_r[in_slot_number[SLOT_W-1:0]] <= '0;
              per_r[in_slot_number[SLOT_W-1:0]] <= '0;
              rep_r[in_slot_number[SLOT_W-1:0]] <= '0;
              if (fill_r < (SLOT_W+1)'(SLOT_COUNT)) begin
                fifo_r[tail_r] <= {2'b0, in_slot_number[SLOT_W-1:0]};
                tail_r <= tail_r + 1'b1;
                fill_r <= fill_r + 1'b1;
              end
            end
          end else if (in_command == CMD_TICK) begin
            ticks_r <= ticks_r + 32'd1;
            idx_r <= '0;
            scan_end_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_end_r) begin
            out_kind <= KIND_TICK;
            out_status <= ST_OK;
            out_result_slot <= '0;
            out_fired_handler <= '0;
            out_tick_count <= ticks_r;
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state_r <= S_OUT;
          end else if (req.start) state_r <= S_WAIT;
          else begin
            idx_r <= idx_r + 1'b1;
            scan_end_r <= (idx_r == SLOT_W'(SLOT_COUNT-1));
          end
        end
        S_WAIT: if (rsp.done) begin
          if (rsp.zero) begin
            out_kind <= KIND_FIRE;
            out_status <= ST_OK;
            out_result_slot <= {2'b0, idx_r};
            out_fired_handler <= hnd_r[idx_r];
            out_tick_count <= '0;
            out_last <= 1'b0;
            out_valid <= 1'b1;
            rep_r[idx_r] <= rep_dec;
            if (rep_dec == 16'sd0) begin
              hnd_r[idx_r] <= '0;
              per_r[idx_r] <= '0;
              if (fill_r < (SLOT_W+1)'(SLOT_COUNT)) begin
                fifo_r[tail_r] <= {2'b0, idx_r};
                tail_r <= tail_r + 1'b1;
                fill_r <= fill_r + 1'b1;
              end
            end
            state_r <= S_FIRE;
          end else begin
            idx_r <= idx_r + 1'b1;
            scan_end_r <= (idx_r == SLOT_W'(SLOT_COUNT-1));
            state_r <= S_SCAN;
          end
        end
        S_FIRE: if (!out_stall) begin
          out_valid <= 1'b0;
          idx_r <= idx_r + 1'b1;
          scan_end_r <= (idx_r == SLOT_W'(SLOT_COUNT-1));
          state_r <= S_SCAN;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (SLOT_W+1)'(SLOT_COUNT)) else $error("fill count overflow");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while word pending");
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRE |-> !out_last) else $error("fire word marked last");
  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TICK |-> out_last) else $error("tick word not last");
endmodule
`default_nettype wire
